// File: rtl/tni_pkg.sv
// ----------------------------------------------------------------------------
// tni_pkg
// Shared constants and types for the torus neighbor index block.
// ----------------------------------------------------------------------------
package tni_pkg;

  // Fixed field widths.
  localparam int SITE_W = 30;
  localparam int CFG_W  = 11;
  localparam int DIR_W  = 3;

  // Stream data widths, padded to whole bytes; tuser carries the bare direction.
  localparam int IN_TDATA_W  = 32;
  localparam int OUT_TDATA_W = 32;
  localparam int OUT_TUSER_W = DIR_W;

  // Restoring division: quotient bits resolved per pipeline stage.
  localparam int DIV_STEPS  = 5;
  localparam int DIV_STAGES = SITE_W / DIV_STEPS;

  // Parameter defaults.
  localparam int DIMS_DEF      = 3;
  localparam int SIDE_BITS_DEF = 10;

  // Side length after reset.
  localparam logic [CFG_W-1:0] CFG_SIDE_RST = 11'd16;

  typedef logic [SITE_W-1:0] site_t;

endpackage

// File: rtl/tni_divider.sv
// ----------------------------------------------------------------------------
// tni_divider
// Pipelined mixed-radix split of a flat site index into lattice coordinates.
// ----------------------------------------------------------------------------
module tni_divider #(
  parameter int DIMS      = tni_pkg::DIMS_DEF,
  parameter int SIDE_BITS = tni_pkg::SIDE_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              en,
  input  logic [SIDE_BITS:0]                side,
  input  logic                              in_valid,
  input  tni_pkg::site_t                    in_site,
  output logic                              out_valid,
  output logic [DIMS-1:0][SIDE_BITS-1:0]    out_pos
);

  localparam int SB1  = SIDE_BITS + 1;
  localparam int NSTG = DIMS * tni_pkg::DIV_STAGES;

  typedef struct packed {
    logic [SIDE_BITS-1:0]      rem;
    logic [tni_pkg::SITE_W-1:0] quo;
  } div_st_t;

  // DIV_STEPS restoring division steps: shift in one dividend bit, subtract if it fits.
  function automatic div_st_t div_steps(div_st_t cur, logic [SB1-1:0] s);
    div_st_t        r;
    logic [SB1-1:0] t;
    r = cur;
    for (int k = 0; k < tni_pkg::DIV_STEPS; k++) begin
      t     = {r.rem, r.quo[tni_pkg::SITE_W-1]};
      r.quo = {r.quo[tni_pkg::SITE_W-2:0], 1'b0};
      if (t >= s) begin
        t        = t - s;
        r.quo[0] = 1'b1;
      end
      r.rem = t[SIDE_BITS-1:0];
    end
    return r;
  endfunction

  logic                           v_r   [NSTG];
  div_st_t                        st_r  [NSTG];
  logic [DIMS-1:0][SIDE_BITS-1:0] pos_r [NSTG];

  for (genvar j = 0; j < NSTG; j++) begin : g_stage
    logic                           v_in;
    div_st_t                        st_in;
    logic [DIMS-1:0][SIDE_BITS-1:0] pos_in;

    // Stage input: a new site, the start of the next division, or the running one.
    if (j == 0) begin : g_first
      always_comb begin
        v_in       = in_valid;
        st_in.rem  = '0;
        st_in.quo  = in_site;
        pos_in     = '0;
      end
    end else if ((j % tni_pkg::DIV_STAGES) == 0) begin : g_next_div
      always_comb begin
        v_in       = v_r[j-1];
        st_in.rem  = '0;
        st_in.quo  = st_r[j-1].quo;
        pos_in     = pos_r[j-1];
        pos_in[DIMS - (j / tni_pkg::DIV_STAGES)] = st_r[j-1].rem;
      end
    end else begin : g_cont
      always_comb begin
        v_in   = v_r[j-1];
        st_in  = st_r[j-1];
        pos_in = pos_r[j-1];
      end
    end

    // Valid bit of the stage.
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[j] <= 1'b0;
      end else if (en) begin
        v_r[j] <= v_in;
      end
    end

    // Stage payload.
    always_ff @(posedge clk) begin
      if (en) begin
        st_r[j]  <= div_steps(st_in, side);
        pos_r[j] <= pos_in;
      end
    end
  end

  // The last remainder is the top coordinate.
  always_comb begin
    out_valid  = v_r[NSTG-1];
    out_pos    = pos_r[NSTG-1];
    out_pos[0] = st_r[NSTG-1].rem;
  end

endmodule

// File: rtl/tni_recomb.sv
// ----------------------------------------------------------------------------
// tni_recomb
// Rebuilds the wrapped flat site index from its coordinates, one Horner step
// per stage.
// ----------------------------------------------------------------------------
module tni_recomb #(
  parameter int DIMS      = tni_pkg::DIMS_DEF,
  parameter int SIDE_BITS = tni_pkg::SIDE_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           en,
  input  logic [SIDE_BITS:0]             side,
  input  logic                           in_valid,
  input  logic [DIMS-1:0][SIDE_BITS-1:0] in_pos,
  output logic                           out_valid,
  output tni_pkg::site_t                 out_site,
  output logic [DIMS-1:0][SIDE_BITS-1:0] out_pos
);

  localparam int SB1 = SIDE_BITS + 1;
  localparam int PW  = tni_pkg::SITE_W + SB1;

  if (DIMS == 1) begin : g_single
    // A single coordinate is already the flat index.
    assign out_valid = in_valid;
    assign out_site  = tni_pkg::SITE_W'(in_pos[0]);
    assign out_pos   = in_pos;
  end else begin : g_horner
    localparam int NH = DIMS - 1;

    logic                           v_r   [NH];
    tni_pkg::site_t                 acc_r [NH];
    logic [DIMS-1:0][SIDE_BITS-1:0] pos_r [NH];

    for (genvar h = 0; h < NH; h++) begin : g_stage
      logic                           v_prev;
      tni_pkg::site_t                 acc_prev;
      logic [DIMS-1:0][SIDE_BITS-1:0] pos_prev;
      logic [PW-1:0]                  prod;
      tni_pkg::site_t                 acc_nxt;

      if (h == 0) begin : g_first
        assign v_prev   = in_valid;
        assign acc_prev = tni_pkg::SITE_W'(in_pos[0]);
        assign pos_prev = in_pos;
      end else begin : g_rest
        assign v_prev   = v_r[h-1];
        assign acc_prev = acc_r[h-1];
        assign pos_prev = pos_r[h-1];
      end

      // One multiply by the side and one add of the next coordinate, kept modulo 2^30.
      always_comb begin
        prod    = PW'(acc_prev) * PW'(side);
        acc_nxt = prod[tni_pkg::SITE_W-1:0] + tni_pkg::SITE_W'(pos_prev[h+1]);
      end

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          v_r[h] <= 1'b0;
        end else if (en) begin
          v_r[h] <= v_prev;
        end
      end

      always_ff @(posedge clk) begin
        if (en) begin
          acc_r[h] <= acc_nxt;
          pos_r[h] <= pos_prev;
        end
      end
    end

    assign out_valid = v_r[NH-1];
    assign out_site  = acc_r[NH-1];
    assign out_pos   = pos_r[NH-1];
  end

endmodule

// File: rtl/tni_emit.sv
// ----------------------------------------------------------------------------
// tni_emit
// Holds one site and sends its 2*DIMS neighbor beats through an output
// register.
// ----------------------------------------------------------------------------
module tni_emit #(
  parameter int DIMS      = tni_pkg::DIMS_DEF,
  parameter int SIDE_BITS = tni_pkg::SIDE_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic [SIDE_BITS:0]             side,
  input  logic                           in_valid,
  input  tni_pkg::site_t                 in_site,
  input  logic [DIMS-1:0][SIDE_BITS-1:0] in_pos,
  output logic                           in_take,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output tni_pkg::site_t                 out_site,
  output logic [tni_pkg::DIR_W-1:0]      out_dir,
  output logic                           out_last
);

  localparam int SB1 = SIDE_BITS + 1;
  localparam int CW  = $clog2(2 * DIMS);
  localparam int DW  = (DIMS > 1) ? $clog2(DIMS) : 1;
  localparam logic [CW-1:0] LAST_BEAT = CW'(2 * DIMS - 1);

  // Powers of the side; power 0 is the constant one. Each power is registered
  // from the one below it and settles well before a site gets through the divider.
  tni_pkg::site_t pw_w   [DIMS+1];
  tni_pkg::site_t pw_r   [1:DIMS];
  tni_pkg::site_t step_w [DIMS];
  tni_pkg::site_t span_r [DIMS];

  assign pw_w[0] = tni_pkg::SITE_W'(1);

  for (genvar e = 1; e <= DIMS; e++) begin : g_pow
    logic [tni_pkg::SITE_W+SB1-1:0] prod;
    assign prod    = (tni_pkg::SITE_W+SB1)'(pw_w[e-1]) * (tni_pkg::SITE_W+SB1)'(side);
    assign pw_w[e] = pw_r[e];
    always_ff @(posedge clk) begin
      pw_r[e] <= prod[tni_pkg::SITE_W-1:0];
    end
  end

  // Per dimension: the unit step and the wrap span (side-1 steps).
  for (genvar d = 0; d < DIMS; d++) begin : g_span
    assign step_w[d] = pw_w[DIMS-1-d];
    always_ff @(posedge clk) begin
      span_r[d] <= pw_w[DIMS-d] - pw_w[DIMS-1-d];
    end
  end

  // Held site and beat counter.
  logic                           it_v_r;
  tni_pkg::site_t                 it_site_r;
  logic [DIMS-1:0][SIDE_BITS-1:0] it_pos_r;
  logic [CW-1:0]                  cnt_r;

  logic                           out_v_r;
  tni_pkg::site_t                 out_site_r;
  logic [tni_pkg::DIR_W-1:0]      out_dir_r;
  logic                           out_last_r;

  logic                           load_out;
  logic                           last_beat;
  logic [DW-1:0]                  d_sel;
  logic [SIDE_BITS-1:0]           pos_d;
  logic                           at_low;
  logic                           at_high;
  tni_pkg::site_t                 nb_nxt;

  assign load_out  = it_v_r && (!out_v_r || out_tready);
  assign last_beat = (cnt_r == LAST_BEAT);
  assign in_take   = !it_v_r || (load_out && last_beat);

  // Neighbor of the current beat: one step or one wrap span away.
  always_comb begin
    d_sel   = DW'(cnt_r >> 1);
    pos_d   = it_pos_r[d_sel];
    at_low  = (pos_d == '0);
    at_high = (SB1'(pos_d) == side - SB1'(1));
    if (cnt_r[0]) begin
      nb_nxt = at_high ? it_site_r - span_r[d_sel] : it_site_r + step_w[d_sel];
    end else begin
      nb_nxt = at_low ? it_site_r + span_r[d_sel] : it_site_r - step_w[d_sel];
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      it_v_r  <= 1'b0;
      cnt_r   <= '0;
      out_v_r <= 1'b0;
    end else begin
      if (in_take) begin
        it_v_r <= in_valid;
      end
      if (load_out) begin
        cnt_r <= last_beat ? '0 : cnt_r + CW'(1);
      end
      if (load_out) begin
        out_v_r <= 1'b1;
      end else if (out_tready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_take && in_valid) begin
      it_site_r <= in_site;
      it_pos_r  <= in_pos;
    end
    if (load_out) begin
      out_site_r <= nb_nxt;
      out_dir_r  <= tni_pkg::DIR_W'(cnt_r);
      out_last_r <= last_beat;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_site   = out_site_r;
  assign out_dir    = out_dir_r;
  assign out_last   = out_last_r;

endmodule

// File: rtl/torus_neighbor_index.sv
// ----------------------------------------------------------------------------
// torus_neighbor_index
// Nearest neighbors of a site on a periodic cubic lattice of DIMS dimensions.
//
//   channel  dir  ports                          content
//   in_      in   in_tvalid/in_tready/in_tdata   flat site index
//   out_     out  out_tvalid/out_tready/out_*    one neighbor per beat
//   cfg_     in   cfg_wr_en/cfg_wr_data          side length
//
// Each site yields 2*DIMS output beats through the single output register;
// the emitter takes the next site only as the held one's last beat loads. A
// site is accepted in every cycle while the pipeline has room. The first
// beat follows DIMS*6 divider and DIMS-1 Horner stages, then the held-site
// and output registers. Reset is synchronous and restores a side length of
// 16; there is no clearing pass. A low out_tready holds the output beat and
// backs up the pipeline to in_tready without losing or repeating anything.
// ----------------------------------------------------------------------------
module torus_neighbor_index #(
  parameter int DIMS      = tni_pkg::DIMS_DEF,
  parameter int SIDE_BITS = tni_pkg::SIDE_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // Configuration: side_length.
  input  logic                             cfg_wr_en,
  input  logic [tni_pkg::CFG_W-1:0]        cfg_wr_data,
  // Input stream. tdata: site_index[29:0], zero pad.
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [tni_pkg::IN_TDATA_W-1:0]   in_tdata,
  // Output stream. tdata: neighbor_site[29:0], zero pad. tuser: direction[2:0].
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [tni_pkg::OUT_TDATA_W-1:0]  out_tdata,
  output logic [tni_pkg::OUT_TUSER_W-1:0]  out_tuser,
  output logic                             out_tlast
);

  localparam int SB1 = SIDE_BITS + 1;
  localparam logic [SB1-1:0] SIDE_MAX = SB1'(1) << SIDE_BITS;
  localparam logic [tni_pkg::DIR_W-1:0] LAST_DIR = tni_pkg::DIR_W'(2 * DIMS - 1);

  logic [tni_pkg::CFG_W-1:0]      cfg_side_r;
  logic [SB1-1:0]                 side_eff;
  logic                           pipe_en;
  logic                           div_v;
  logic [DIMS-1:0][SIDE_BITS-1:0] div_pos;
  logic                           tail_v;
  tni_pkg::site_t                 tail_site;
  logic [DIMS-1:0][SIDE_BITS-1:0] tail_pos;
  logic                           emit_take;
  tni_pkg::site_t                 nb_site;
  logic [tni_pkg::DIR_W-1:0]      nb_dir;

  // Side length register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_side_r <= tni_pkg::CFG_SIDE_RST;
    end else if (cfg_wr_en) begin
      cfg_side_r <= cfg_wr_data;
    end
  end

  // A side of zero acts as one; a side above the coordinate range saturates.
  always_comb begin
    if (cfg_side_r == '0) begin
      side_eff = SB1'(1);
    end else if (32'(cfg_side_r) > (32'd1 << SIDE_BITS)) begin
      side_eff = SIDE_MAX;
    end else begin
      side_eff = SB1'(cfg_side_r);
    end
  end

  // The pipeline moves when its last stage is empty or hands its site over.
  assign pipe_en   = !tail_v || emit_take;
  assign in_tready = pipe_en;

  tni_divider #(
    .DIMS      (DIMS),
    .SIDE_BITS (SIDE_BITS)
  ) u_divider (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (pipe_en),
    .side      (side_eff),
    .in_valid  (in_tvalid),
    .in_site   (in_tdata[tni_pkg::SITE_W-1:0]),
    .out_valid (div_v),
    .out_pos   (div_pos)
  );

  tni_recomb #(
    .DIMS      (DIMS),
    .SIDE_BITS (SIDE_BITS)
  ) u_recomb (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (pipe_en),
    .side      (side_eff),
    .in_valid  (div_v),
    .in_pos    (div_pos),
    .out_valid (tail_v),
    .out_site  (tail_site),
    .out_pos   (tail_pos)
  );

  tni_emit #(
    .DIMS      (DIMS),
    .SIDE_BITS (SIDE_BITS)
  ) u_emit (
    .clk        (clk),
    .rst_n      (rst_n),
    .side       (side_eff),
    .in_valid   (tail_v),
    .in_site    (tail_site),
    .in_pos     (tail_pos),
    .in_take    (emit_take),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_site   (nb_site),
    .out_dir    (nb_dir),
    .out_last   (out_tlast)
  );

  assign out_tdata = {{(tni_pkg::OUT_TDATA_W - tni_pkg::SITE_W){1'b0}}, nb_site};
  assign out_tuser = nb_dir;

`ifndef SYNTHESIS
  // Input stalls only when a finished site waits for the emitter.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (tail_v && !emit_take))
    else $error("input stalled without a waiting site");

  // A waiting site is not dropped while the emitter is busy.
  a_tail_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (tail_v && !emit_take) |=> (tail_v && $stable(tail_site)))
    else $error("pipeline tail lost under stall");

  // The effective side always lies on the lattice range.
  a_side_range: assert property (@(posedge clk) disable iff (!rst_n)
    (side_eff != '0) && (side_eff <= SIDE_MAX))
    else $error("effective side out of range");

  // The last beat of a site carries the final direction.
  a_last_dir: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tlast) |-> (out_tuser == LAST_DIR))
    else $error("last beat with wrong direction");
`endif

endmodule

// File: test/tb_torus_neighbor_index.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_torus_neighbor_index
// Self-checking bench for the periodic lattice neighbor block. Each accepted
// site is expanded into its 2*DIMS expected neighbor beats by a local model.
// A monitor compares every output beat, field by field, against the oldest
// expected beat. Stimulus runs directed corner sites, side length extremes,
// random sites over several side settings, and a long receiver hold-off that
// backs the pipeline up to the input. The sender idles in random bursts, and
// the receiver stalls on its own pattern.
// ----------------------------------------------------------------------------
module tb_torus_neighbor_index;

  localparam int DIMS           = tni_pkg::DIMS_DEF;
  localparam int SIDE_BITS      = tni_pkg::SIDE_BITS_DEF;
  localparam int LATENCY        = DIMS * 6 + DIMS - 1 + 2;
  localparam int SETTLE_CYCLES  = 2 * LATENCY;
  localparam int HOLD_OFF_LEN   = 300;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int MAX_REPORTS    = 10;

  // One expected output beat.
  typedef struct packed {
    tni_pkg::site_t            site;
    logic [tni_pkg::DIR_W-1:0] dir;
    logic                      last;
  } neighbor_beat_t;

  logic                            clk         = 1'b0;
  logic                            rst_n       = 1'b0;
  logic                            cfg_wr_en   = 1'b0;
  logic [tni_pkg::CFG_W-1:0]       cfg_wr_data = '0;
  logic                            in_tvalid   = 1'b0;
  logic                            in_tready;
  logic [tni_pkg::IN_TDATA_W-1:0]  in_tdata    = '0;
  logic                            out_tvalid;
  logic                            out_tready  = 1'b0;
  logic [tni_pkg::OUT_TDATA_W-1:0] out_tdata;
  logic [tni_pkg::OUT_TUSER_W-1:0] out_tuser;
  logic                            out_tlast;

  // Local copy of the side length register.
  logic [tni_pkg::CFG_W-1:0] side_reg = tni_pkg::CFG_SIDE_RST;

  neighbor_beat_t pending_neighbors[$];
  int             mismatches    = 0;
  int             sites_sent    = 0;
  int             beats_checked = 0;
  int             side_settings = 1;
  int             idle_cycles   = 0;

  // Sender burst control and receiver stall control.
  bit tx_gappy     = 1'b1;
  int burst_left   = 0;
  int rx_mode      = 0;
  bit hold_off_req = 1'b0;

  torus_neighbor_index #(
    .DIMS      (DIMS),
    .SIDE_BITS (SIDE_BITS)
  ) u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),    // site_index[29:0], zero pad
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),   // neighbor_site[29:0], zero pad
    .out_tuser   (out_tuser),   // direction[2:0]
    .out_tlast   (out_tlast)
  );

  always #1 clk = ~clk;

  // Side length as the block uses it: zero acts as one, large values saturate.
  function automatic longint unsigned lattice_side(input logic [tni_pkg::CFG_W-1:0] v);
    longint unsigned s;
    s = v;
    if (s == 0) s = 1;
    if (s > (64'd1 << SIDE_BITS)) s = 64'd1 << SIDE_BITS;
    return s;
  endfunction

  // Expand one site into its minus and plus neighbors along every dimension.
  function automatic void predict_neighbors(input tni_pkg::site_t site);
    longint unsigned side, rest, flat, mult;
    longint unsigned pos[DIMS];
    longint unsigned nb[DIMS];
    neighbor_beat_t  beat;
    int              i, d, s;
    side = lattice_side(side_reg);
    rest = site;
    for (i = DIMS - 1; i >= 0; i--) begin
      pos[i] = rest % side;
      rest   = rest / side;
    end
    for (d = 0; d < DIMS; d++) begin
      for (s = 0; s < 2; s++) begin
        nb = pos;
        if (s == 0) nb[d] = (pos[d] == 0) ? side - 1 : pos[d] - 1;
        else        nb[d] = (pos[d] + 1 >= side) ? 0 : pos[d] + 1;
        flat = 0;
        mult = 1;
        for (i = DIMS - 1; i >= 0; i--) begin
          flat += nb[i] * mult;
          mult *= side;
        end
        beat.site = flat[tni_pkg::SITE_W-1:0];
        beat.dir  = tni_pkg::DIR_W'(2 * d + s);
        beat.last = (d == DIMS - 1) && (s == 1);
        pending_neighbors = {pending_neighbors, beat};
      end
    end
  endfunction

  // Offer one site, with a random gap when a burst runs out.
  task automatic send_site(input tni_pkg::site_t site);
    int gap;
    if (tx_gappy && burst_left == 0) begin
      gap        = $urandom_range(1, 6);
      burst_left = $urandom_range(1, 10);
      in_tvalid <= 1'b0;
      in_tdata  <= $urandom;
      repeat (gap) @(posedge clk);
    end
    if (burst_left > 0) burst_left--;
    in_tvalid <= 1'b1;
    in_tdata  <= tni_pkg::IN_TDATA_W'(site);
    do @(posedge clk); while (!in_tready);
    predict_neighbors(site);
    sites_sent++;
  endtask

  // Stop offering, let every expected beat arrive, then let the pipeline settle.
  task automatic drain_pipeline();
    in_tvalid <= 1'b0;
    while (pending_neighbors.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write the side length while the block is idle.
  task automatic configure_side(input logic [tni_pkg::CFG_W-1:0] v);
    drain_pipeline();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    cfg_wr_data <= $urandom;
    side_reg = v;
    side_settings++;
  endtask

  // Corner sites, lattice overflow and wide indices at the reset side of 16.
  task automatic test_reset_side();
    rx_mode  = 1;
    tx_gappy = 1'b1;
    send_site(30'd0);
    send_site(30'd4095);
    send_site(30'd15);
    send_site(30'd240);
    send_site(30'd3840);
    send_site(30'd4096);
    send_site(30'h3FFF_FFFF);
    send_site(30'h2AAA_AAAA);
    send_site(30'h1555_5555);
  endtask

  // Side lengths of zero, one, two, the maximum and values beyond it.
  task automatic test_side_extremes();
    configure_side(11'd0);
    send_site(30'd7);
    send_site(30'h3FFF_FFFF);
    configure_side(11'd1);
    send_site(30'd5);
    send_site(30'h3FFF_FFFF);
    configure_side(11'd2);
    send_site(30'd0);
    send_site(30'd7);
    send_site(30'd9);
    configure_side(11'd1024);
    send_site(30'd0);
    send_site(30'h3FFF_FFFF);
    send_site(30'h2000_0000);
    configure_side(11'd1025);
    send_site(30'h3FFF_FFFF);
    configure_side(11'd2047);
    send_site(30'h3FFF_FFFF);
    send_site(30'd1023);
  endtask

  // Random sites over several sides: mostly on the lattice, some pinned to
  // the lattice edges, some raw 30-bit indices that wrap around.
  task automatic test_random_sites();
    int unsigned               side_list[8] = '{3, 7, 2, 1023, 1024, 5, 16, 0};
    int                        phase, n, i;
    int unsigned               kind, pick;
    longint unsigned           side, cells, flat, coord;
    logic [tni_pkg::CFG_W-1:0] v;
    for (phase = 0; phase < 8; phase++) begin
      v = (phase == 7) ? tni_pkg::CFG_W'($urandom_range(0, 2047)) :
                         tni_pkg::CFG_W'(side_list[phase]);
      configure_side(v);
      rx_mode  = phase % 3;
      tx_gappy = (phase != 2);
      side  = lattice_side(v);
      cells = side ** DIMS;
      if (cells > (64'd1 << tni_pkg::SITE_W)) cells = 64'd1 << tni_pkg::SITE_W;
      for (n = 0; n < 23; n++) begin
        kind = $urandom_range(0, 9);
        if (kind < 6) begin
          flat = $urandom_range(0, int'(cells - 1));
        end else if (kind < 8) begin
          flat = 0;
          for (i = 0; i < DIMS; i++) begin
            pick  = $urandom_range(0, 2);
            coord = (pick == 0) ? 0 : (pick == 1) ? side - 1 :
                    $urandom_range(0, int'(side - 1));
            flat  = flat * side + coord;
          end
        end else begin
          flat = $urandom_range(0, 32'h3FFF_FFFF);
        end
        send_site(flat[tni_pkg::SITE_W-1:0]);
      end
    end
  endtask

  // Receiver holds off for a long stretch while sites keep coming back to back.
  task automatic test_backpressure();
    int n;
    configure_side(11'd10);
    rx_mode      = 0;
    tx_gappy     = 1'b0;
    hold_off_req <= 1'b1;
    for (n = 0; n < 48; n++) send_site(tni_pkg::SITE_W'($urandom_range(0, 999)));
    tx_gappy = 1'b1;
  endtask

  // Receiver: a long hold-off on request, otherwise the current stall pattern.
  initial begin : rx_stall
    int cyc;
    int n;
    cyc = 0;
    forever begin
      @(posedge clk);
      cyc++;
      if (hold_off_req) begin
        hold_off_req <= 1'b0;
        out_tready   <= 1'b0;
        for (n = 0; n < HOLD_OFF_LEN; n++) @(posedge clk);
      end else begin
        case (rx_mode)
          0:       out_tready <= 1'b1;
          1:       out_tready <= ($urandom_range(0, 3) != 0);
          default: out_tready <= ((cyc % 7) < 4);
        endcase
      end
    end
  end

  // Compare every output beat with the oldest expected neighbor.
  always @(posedge clk) begin
    neighbor_beat_t exp_beat;
    if (rst_n && out_tvalid === 1'b1 && out_tready) begin
      if (pending_neighbors.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected beat: tdata=%h tuser=%0d tlast=%b",
                   out_tdata, out_tuser, out_tlast);
      end else begin
        exp_beat = pending_neighbors.pop_front();
        beats_checked++;
        if (out_tdata !== tni_pkg::OUT_TDATA_W'(exp_beat.site) ||
            out_tuser !== exp_beat.dir || out_tlast !== exp_beat.last) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("beat %0d mismatch: exp site=%0d dir=%0d last=%b, got %0d/%0d/%b",
                     beats_checked, exp_beat.site, exp_beat.dir, exp_beat.last,
                     out_tdata, out_tuser, out_tlast);
        end
      end
    end
  end

  // Watchdog: ends the run when no beat moves on either side for too long.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("timeout: no beat for %0d cycles, %0d neighbors outstanding",
               idle_cycles, pending_neighbors.size());
      $display("tb_torus_neighbor_index: errors");
      $finish;
    end
  end

  // Test sequence.
  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_side();
    test_side_extremes();
    test_random_sites();
    test_backpressure();
    drain_pipeline();
    $display("Checked %0d neighbor beats from %0d sites over %0d side settings,",
             beats_checked, sites_sent, side_settings);
    $display("including a %0d-cycle output hold-off; %0d mismatches.",
             HOLD_OFF_LEN, mismatches);
    if (mismatches == 0) $display("tb_torus_neighbor_index: clean");
    else $display("tb_torus_neighbor_index: errors");
    $finish;
  end

endmodule

// File: filelist.f
rtl/tni_pkg.sv
rtl/tni_divider.sv
rtl/tni_recomb.sv
rtl/tni_emit.sv
rtl/torus_neighbor_index.sv
test/tb_torus_neighbor_index.sv
